[rtl/cvp_pkg.sv]
package cvp_pkg;

  localparam int ANGLE_WIDTH = 17;
  localparam int ATAN_DEPTH = 16;
  localparam int GAIN_SHIFT = 16;
  localparam int GAIN_WIDTH = 17;

  localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI = 17'sd16384;
  localparam logic signed [GAIN_WIDTH-1:0] GAIN_COMP = 17'sd39797;

  localparam logic signed [ANGLE_WIDTH-1:0] ATAN_TABLE [ATAN_DEPTH] = '{
    17'sd8192, 17'sd4836, 17'sd2555, 17'sd1297, 17'sd651, 17'sd326, 17'sd163, 17'sd81,
    17'sd41, 17'sd20, 17'sd10, 17'sd5, 17'sd3, 17'sd1, 17'sd1, 17'sd0
  };

  function automatic int atan_sum(input int n);
    int s;
    s = 0;
    for (int i = 0; i < ATAN_DEPTH; i++) begin
      if (i < n) begin
        s = s + int'(ATAN_TABLE[i]);
      end
    end
    return s;
  endfunction

endpackage

[rtl/cordic_vector_to_polar_core.sv]
// Pipeline registers in order: quadrant fold, one stage per micro-rotation,
// gain multiply, saturate into the result register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds while the result register is full and out_ready is low.
// Reset: synchronous, clears only the valid bits of every stage.
module cordic_vector_to_polar_core
  import cvp_pkg::*;
#(
  parameter int ITERATIONS = 14,
  parameter int DATA_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  real_part,
  input  logic signed [DATA_WIDTH-1:0]  imag_part,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [DATA_WIDTH-1:0]  magnitude,
  output logic signed [ANGLE_WIDTH-1:0] angle
);

  localparam int XW = DATA_WIDTH + 3;
  localparam int PW = XW + GAIN_WIDTH;
  localparam int MW = PW - GAIN_SHIFT;
  localparam logic signed [ANGLE_WIDTH-1:0] ANG_LIMIT =
    ANGLE_WIDTH'(int'(HALF_PI) + atan_sum(ITERATIONS));

  logic enable;

  logic                          valid_s [ITERATIONS+1];
  logic signed [XW-1:0]          x_s     [ITERATIONS+1];
  logic signed [XW-1:0]          y_s     [ITERATIONS+1];
  logic signed [ANGLE_WIDTH-1:0] ang_s   [ITERATIONS+1];

  logic signed [XW-1:0]          re_w;
  logic signed [XW-1:0]          im_w;
  logic signed [XW-1:0]          x0_next;
  logic signed [XW-1:0]          y0_next;
  logic signed [ANGLE_WIDTH-1:0] ang0_next;

  logic                          valid_m;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_next;
  logic signed [ANGLE_WIDTH-1:0] ang_m;

  logic signed [MW-1:0]          mag_wide;
  logic        [DATA_WIDTH-1:0]  magnitude_next;

  assign enable   = !out_valid || out_ready;
  assign in_ready = enable;

  assign re_w = {{3{real_part[DATA_WIDTH-1]}}, real_part};
  assign im_w = {{3{imag_part[DATA_WIDTH-1]}}, imag_part};

  always_comb begin
    if (re_w[XW-1]) begin
      if (im_w[XW-1]) begin
        x0_next   = -im_w;
        y0_next   = re_w;
        ang0_next = -HALF_PI;
      end else begin
        x0_next   = im_w;
        y0_next   = -re_w;
        ang0_next = HALF_PI;
      end
    end else begin
      x0_next   = re_w;
      y0_next   = im_w;
      ang0_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (enable) begin
      valid_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      x_s[0]   <= x0_next;
      y_s[0]   <= y0_next;
      ang_s[0] <= ang0_next;
    end
  end

  for (genvar k = 0; k < ITERATIONS; k++) begin : g_step
    cvp_stage #(
      .XW    (XW),
      .SHIFT (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .enable    (enable),
      .valid_in  (valid_s[k]),
      .x_in      (x_s[k]),
      .y_in      (y_s[k]),
      .ang_in    (ang_s[k]),
      .valid_out (valid_s[k+1]),
      .x_out     (x_s[k+1]),
      .y_out     (y_s[k+1]),
      .ang_out   (ang_s[k+1])
    );
  end

  assign prod_next = $signed(PW'(x_s[ITERATIONS])) * $signed(PW'(GAIN_COMP));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_m <= 1'b0;
    end else if (enable) begin
      valid_m <= valid_s[ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      prod  <= prod_next;
      ang_m <= ang_s[ITERATIONS];
    end
  end

  assign mag_wide = prod[PW-1:GAIN_SHIFT];

  always_comb begin
    if (mag_wide[MW-1]) begin
      magnitude_next = '0;
    end else if (|mag_wide[MW-1:DATA_WIDTH]) begin
      magnitude_next = '1;
    end else begin
      magnitude_next = mag_wide[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (enable) begin
      out_valid <= valid_m;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      magnitude <= magnitude_next;
      angle     <= ang_m;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(magnitude) && $stable(angle))
    else $error("result changed while stalled");

  a_ready_only_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without a stalled result");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle <= ANG_LIMIT && angle >= -ANG_LIMIT)
    else $error("angle outside accumulated table range");

  a_x_nonneg: assert property (@(posedge clk) disable iff (rst)
    valid_s[ITERATIONS] |-> !x_s[ITERATIONS][XW-1])
    else $error("rotated real part went negative");

  a_request_reaches_mul: assert property (@(posedge clk) disable iff (rst)
    enable && valid_s[ITERATIONS] |=> valid_m)
    else $error("request lost before gain stage");

endmodule

[rtl/cvp_stage.sv]
module cvp_stage
  import cvp_pkg::*;
#(
  parameter int XW = 19,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          enable,
  input  logic                          valid_in,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [ANGLE_WIDTH-1:0] ang_in,
  output logic                          valid_out,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [ANGLE_WIDTH-1:0] ang_out
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic signed [ANGLE_WIDTH-1:0] ang_next;

  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_comb begin
    if (y_in[XW-1]) begin
      x_next   = x_in - ys;
      y_next   = y_in + xs;
      ang_next = ang_in - ATAN_TABLE[SHIFT];
    end else begin
      x_next   = x_in + ys;
      y_next   = y_in - xs;
      ang_next = ang_in + ATAN_TABLE[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (enable) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      x_out   <= x_next;
      y_out   <= y_next;
      ang_out <= ang_next;
    end
  end

endmodule
